// ----- rtl/ealu_pkg.sv -----
`default_nettype none

package ealu_pkg;

    // operation codes
    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_ADC   = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_SBC   = 5'd3;
    localparam logic [4:0] OP_AND   = 5'd4;
    localparam logic [4:0] OP_OR    = 5'd5;
    localparam logic [4:0] OP_XOR   = 5'd6;
    localparam logic [4:0] OP_CP    = 5'd7;
    localparam logic [4:0] OP_RLC   = 5'd8;
    localparam logic [4:0] OP_RL    = 5'd9;
    localparam logic [4:0] OP_RRC   = 5'd10;
    localparam logic [4:0] OP_RR    = 5'd11;
    localparam logic [4:0] OP_CPL   = 5'd12;
    localparam logic [4:0] OP_INC8  = 5'd13;
    localparam logic [4:0] OP_DEC8  = 5'd14;
    localparam logic [4:0] OP_ADD16 = 5'd15;
    localparam logic [4:0] OP_INC16 = 5'd16;
    localparam logic [4:0] OP_DEC16 = 5'd17;

    // flag bit positions in the flag byte
    localparam int FLAG_Z = 7;
    localparam int FLAG_C = 4;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [15:0] a_value;
        logic [15:0] b_value;
        logic [7:0]  flags_in;
    } cmd_t;

    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  flags_out;
    } res_t;

    // operand setup stage
    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] a;
        logic [7:0]  f;
        logic [15:0] x;
        logic [15:0] y;
        logic        ci;
    } s1_t;

    // execute stage
    typedef struct packed {
        logic [4:0]  op;
        logic [7:0]  f;
        logic [15:0] r;
        logic [7:0]  zb;
        logic        h;
        logic        c;
    } s2_t;

endpackage

`default_nettype wire

// ----- rtl/ealu_calc.sv -----
`default_nettype none

module ealu_calc (
    input  wire ealu_pkg::s1_t s1,
    output ealu_pkg::s2_t      s2
);
    import ealu_pkg::*;

    logic [16:0] sum;
    logic        c4;
    logic        c8;
    logic        c12;
    logic        c16;
    logic        fc;
    logic [7:0]  a8;

    assign sum = {1'b0, s1.x} + {1'b0, s1.y} + {16'd0, s1.ci};
    // carry into a bit position recovered from the sum bits
    assign c4  = s1.x[4] ^ s1.y[4] ^ sum[4];
    assign c8  = sum[8];
    assign c12 = s1.x[12] ^ s1.y[12] ^ sum[12];
    assign c16 = sum[16];
    assign fc  = s1.f[FLAG_C];
    assign a8  = s1.a[7:0];

    always_comb
    begin
        s2.op = s1.op;
        s2.f  = s1.f;
        s2.r  = s1.a;
        s2.h  = 1'b0;
        s2.c  = 1'b0;
        unique case (s1.op)
            OP_ADD, OP_ADC:
            begin
                s2.r = {8'd0, sum[7:0]};
                s2.h = c4;
                s2.c = c8;
            end
            OP_SUB, OP_SBC:
            begin
                s2.r = {8'd0, sum[7:0]};
                s2.h = ~c4;
                s2.c = ~c8;
            end
            OP_CP:
            begin
                s2.r = s1.a;
                s2.h = ~c4;
                s2.c = ~c8;
            end
            OP_AND:   s2.r = {8'd0, s1.x[7:0] & s1.y[7:0]};
            OP_OR:    s2.r = {8'd0, s1.x[7:0] | s1.y[7:0]};
            OP_XOR:   s2.r = {8'd0, s1.x[7:0] ^ s1.y[7:0]};
            OP_RLC:
            begin
                s2.r = {8'd0, a8[6:0], a8[7]};
                s2.c = a8[7];
            end
            OP_RL:
            begin
                s2.r = {8'd0, a8[6:0], fc};
                s2.c = a8[7];
            end
            OP_RRC:
            begin
                s2.r = {8'd0, a8[0], a8[7:1]};
                s2.c = a8[0];
            end
            OP_RR:
            begin
                s2.r = {8'd0, fc, a8[7:1]};
                s2.c = a8[0];
            end
            OP_CPL:   s2.r = {8'd0, ~a8};
            OP_INC8, OP_DEC8:
                s2.r = {8'd0, sum[7:0]};
            OP_ADD16:
            begin
                s2.r = sum[15:0];
                s2.h = c12;
                s2.c = c16;
            end
            OP_INC16, OP_DEC16:
                s2.r = sum[15:0];
            default:  s2.r = s1.a;
        endcase
        // compare keeps the accumulator but its zero flag follows the difference
        s2.zb = (s1.op == OP_CP) ? sum[7:0] : s2.r[7:0];
    end

endmodule

`default_nettype wire

// ----- rtl/eight_bit_alu_with_flags.sv -----
`default_nettype none

// channel   direction  handshake              payload
// cmd       in         cmd_valid / cmd_stall  ealu_pkg::cmd_t (opcode, operands, flags)
// res       out        res_valid / res_stall  ealu_pkg::res_t (result, flags)
//
// three register stages: operand setup, add/logic/rotate, flag merge into the
// output register; one transaction enters per cycle while cmd_stall is low
// each stage moves on when the stage after it is empty or moving, so bubbles
// close up and cmd_stall only rises when all three stages are full and res is stalled
// rst_n clears the stage valid bits only; payload registers are not reset
module eight_bit_alu_with_flags (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_stall,
    input  wire ealu_pkg::cmd_t  cmd,
    output logic                 res_valid,
    input  wire                  res_stall,
    output ealu_pkg::res_t       res
);
    import ealu_pkg::*;

    // stage valid bits
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    // stage payloads
    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;
    res_t s3_reg;
    res_t s3_next;

    // stage enables, back to front
    logic en1;
    logic en2;
    logic en3;

    assign en3 = ~v3_reg | ~res_stall;
    assign en2 = ~v2_reg | en3;
    assign en1 = ~v1_reg | en2;

    assign cmd_stall = ~en1;
    assign res_valid = v3_reg;
    assign res       = s3_reg;

    // stage 1: pick adder operands and carry in
    // subtract forms add the inverted operand with inverted borrow
    always_comb
    begin
        s1_next.op = cmd.opcode;
        s1_next.a  = cmd.a_value;
        s1_next.f  = cmd.flags_in;
        s1_next.x  = {8'd0, cmd.a_value[7:0]};
        s1_next.y  = 16'd0;
        s1_next.ci = 1'b0;
        unique case (cmd.opcode)
            OP_ADD:   s1_next.y = {8'd0, cmd.b_value[7:0]};
            OP_ADC:
            begin
                s1_next.y  = {8'd0, cmd.b_value[7:0]};
                s1_next.ci = cmd.flags_in[FLAG_C];
            end
            OP_SUB, OP_CP:
            begin
                s1_next.y  = {8'd0, ~cmd.b_value[7:0]};
                s1_next.ci = 1'b1;
            end
            OP_SBC:
            begin
                s1_next.y  = {8'd0, ~cmd.b_value[7:0]};
                s1_next.ci = ~cmd.flags_in[FLAG_C];
            end
            OP_AND, OP_OR, OP_XOR:
                s1_next.y = {8'd0, cmd.b_value[7:0]};
            OP_INC8:  s1_next.ci = 1'b1;
            OP_DEC8:  s1_next.y  = 16'h00FF;
            OP_ADD16:
            begin
                s1_next.x = cmd.a_value;
                s1_next.y = cmd.b_value;
            end
            OP_INC16:
            begin
                s1_next.x  = cmd.a_value;
                s1_next.ci = 1'b1;
            end
            OP_DEC16:
            begin
                s1_next.x = cmd.a_value;
                s1_next.y = 16'hFFFF;
            end
            default:  s1_next.x = {8'd0, cmd.a_value[7:0]};
        endcase
    end

    // stage 2: adder, logic and rotates
    ealu_calc u_calc (
        .s1 (s1_reg),
        .s2 (s2_next)
    );

    // stage 3: zero detect and flag merge
    logic zf;
    logic [3:0] fhi;

    assign zf = (s2_reg.zb == 8'd0);

    always_comb
    begin
        unique case (s2_reg.op)
            OP_ADD, OP_ADC:
                fhi = {zf, 1'b0, s2_reg.h, s2_reg.c};
            OP_SUB, OP_SBC, OP_CP:
                fhi = {zf, 1'b1, s2_reg.h, s2_reg.c};
            OP_AND:
                fhi = {zf, 1'b0, 1'b1, 1'b0};
            OP_OR, OP_XOR:
                fhi = {zf, 3'b000};
            OP_RLC, OP_RL, OP_RRC, OP_RR:
                fhi = {zf, 1'b0, 1'b0, s2_reg.c};
            OP_ADD16:
                fhi = {s2_reg.f[FLAG_Z], 1'b0, s2_reg.h, s2_reg.c};
            default:
                fhi = s2_reg.f[7:4];
        endcase
        s3_next.result    = s2_reg.r;
        s3_next.flags_out = {fhi, s2_reg.f[3:0]};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= cmd_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // payload, loaded only with a live transaction
    always_ff @(posedge clk)
    begin
        if (en1 && cmd_valid)
            s1_reg <= s1_next;
        if (en2 && v1_reg)
            s2_reg <= s2_next;
        if (en3 && v2_reg)
            s3_reg <= s3_next;
    end

    // input held off only with every stage full and the output stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (v1_reg && v2_reg && v3_reg && res_stall))
        else $error("cmd_stall with a free stage");

    // accepted transaction lands in stage 1
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> v1_reg)
        else $error("accepted transaction lost at stage 1");

    // stage 2 moves into the output register when it may
    a_move3: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3) |=> v3_reg)
        else $error("stage 2 transaction lost");

    // output stage drains when taken with nothing behind it
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !res_stall && !v2_reg) |=> !v3_reg)
        else $error("result repeated");

endmodule

`default_nettype wire
